### src/gtcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcr_pkg
// Shared types, constants and codes of the glyph text console renderer.
// ----------------------------------------------------------------------------
package gtcr_pkg;

    // Text grid and glyph range
    localparam int TEXT_COLS          = 80;
    localparam int TEXT_ROWS          = 25;
    localparam int GLYPH_ROWS_DEFAULT = 16;
    localparam int FIRST_GLYPH        = 32;
    localparam int LAST_GLYPH         = 126;
    localparam int CELL_PIXELS        = 8;
    localparam int PIXEL_SHIFT        = 2;

    // Font store
    localparam int STORE_DEPTH = 1520;
    localparam int STORE_AW    = 11;
    localparam int GLYPH_IDX_W = 13;

    // Cursor widths
    localparam int COL_W = 7;
    localparam int ROW_W = 5;

    // Front to back queue
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int REG_IDX_W  = 3;
    localparam int REG_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_FG_COLOR      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BG_COLOR      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LINE_PITCH    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FB_BASE       = 3'd5;

    localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd768;
    localparam logic [15:0] LINE_PITCH_RESET    = 16'd4096;

    // Item codes
    localparam logic       ACTION_LOAD  = 1'b0;
    localparam logic       ACTION_PUT   = 1'b1;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    typedef struct packed {
        logic        action;
        logic [10:0] font_index;
        logic [7:0]  font_byte;
        logic [7:0]  char_code;
    } cmd_t;

    typedef struct packed {
        logic [31:0] row_address;
        logic [31:0] px0;
        logic [31:0] px1;
        logic [31:0] px2;
        logic [31:0] px3;
        logic [31:0] px4;
        logic [31:0] px5;
        logic [31:0] px6;
        logic [31:0] px7;
        logic        last_row;
    } pix_t;

    typedef struct packed {
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [15:0] line_pitch;
        logic [31:0] fb_base;
    } cfg_t;

    typedef enum logic {
        KIND_LOAD,
        KIND_PUT
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t            kind;
        logic [10:0]            font_index;
        logic [7:0]             font_byte;
        logic [GLYPH_IDX_W-1:0] glyph_base;  // two's complement
        logic [COL_W-1:0]       col;
        logic [ROW_W-1:0]       row;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SETUP,
        BK_BASE,
        BK_ROW
    } back_state_t;

endpackage

### src/gtcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gtcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1520
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/gtcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcr_front
// Accepts command beats, tracks the text cursor, absorbs newlines and queues
// font loads and character draws for the back end.
// ----------------------------------------------------------------------------
module gtcr_front
    import gtcr_pkg::*;
#(
    parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    input  q_status_t q_status,
    output logic      push,
    output q_entry_t  entry
);

    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [COL_W-1:0]       draw_col;
    logic [ROW_W-1:0]       draw_row;
    logic                   in_glyph_range;
    logic [6:0]             glyph_code;
    logic [GLYPH_IDX_W-1:0] glyph_diff;
    logic [GLYPH_IDX_W-1:0] glyph_base;
    logic                   accept;

    function automatic logic [ROW_W-1:0] advance_row(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] n;
        n = r + ROW_W'(1);
        if (n >= ROW_W'(TEXT_ROWS))
        begin
            n = '0;
        end
        return n;
    endfunction

    assign cmd_ready = !q_status.full;
    assign accept    = cmd_valid && cmd_ready;

    // Codes from 128 up fail on the top bit alone
    assign in_glyph_range = !cmd.char_code[7]
                         && (cmd.char_code >= 8'(FIRST_GLYPH))
                         && (cmd.char_code <= 8'(LAST_GLYPH));
    assign glyph_code = in_glyph_range ? cmd.char_code[6:0] : CHAR_SPACE[6:0];
    assign glyph_diff = GLYPH_IDX_W'(glyph_code) - GLYPH_IDX_W'(FIRST_GLYPH);
    assign glyph_base = GLYPH_IDX_W'(glyph_diff * GLYPH_IDX_W'(GLYPH_ROWS));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        push     = 1'b0;

        // Wrap a full line before drawing
        draw_col = col_reg;
        draw_row = row_reg;
        if (col_reg >= COL_W'(TEXT_COLS))
        begin
            draw_col = '0;
            draw_row = advance_row(row_reg);
        end

        entry.kind       = KIND_LOAD;
        entry.font_index = cmd.font_index;
        entry.font_byte  = cmd.font_byte;
        entry.glyph_base = glyph_base;
        entry.col        = draw_col;
        entry.row        = draw_row;

        if (accept)
        begin
            if (cmd.action == ACTION_LOAD)
            begin
                push = 1'b1;
            end
            else if (cmd.char_code == CHAR_NEWLINE)
            begin
                col_next = '0;
                row_next = advance_row(row_reg);
            end
            else
            begin
                push       = 1'b1;
                entry.kind = KIND_PUT;
                col_next   = draw_col + COL_W'(1);
                row_next   = draw_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### src/gtcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcr_queue
// Short FIFO of decoded work between the front and the back end.
// ----------------------------------------------------------------------------
module gtcr_queue
    import gtcr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/gtcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcr_back
// Executes queued work: writes font bytes, and for a character computes the
// cell address and walks the glyph rows, one pixel beat per row.
// ----------------------------------------------------------------------------
module gtcr_back
    import gtcr_pkg::*;
#(
    parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  q_entry_t            head,
    input  q_status_t           q_status,
    output logic                pop,
    output logic                ram_we,
    output logic [STORE_AW-1:0] ram_waddr,
    output logic [7:0]          ram_wdata,
    output logic                ram_re,
    output logic [STORE_AW-1:0] ram_raddr,
    input  logic [7:0]          ram_rdata,
    output logic                pix_valid,
    input  logic                pix_ready,
    output pix_t                pix
);

    localparam int GR_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

    back_state_t            state_reg, state_next;
    logic [GR_W-1:0]        grow_reg, grow_next;
    logic                   out_valid_reg, out_valid_next;
    logic [GLYPH_IDX_W-1:0] gbase_reg, gbase_next;
    logic [31:0]            top_reg, top_next;
    logic [31:0]            off_reg, off_next;
    logic [31:0]            prod_reg, prod_next;
    logic [31:0]            addr_reg, addr_next;
    logic                   hit_reg, hit_next;
    pix_t                   out_reg, out_next;
    logic [GR_W-1:0]        rd_row;
    logic [GLYPH_IDX_W-1:0] rd_idx;
    logic                   rd_hit;
    logic [7:0]             bits;
    logic                   slot_free;
    logic [31:0]            top_calc;
    logic [31:0]            left_calc;

    assign slot_free = !out_valid_reg || pix_ready;

    // Cell origin from the queued cursor, centred on the screen
    assign top_calc  = 32'(head.row) * 32'(GLYPH_ROWS)
                     + 32'(cfg.screen_height >> 1)
                     - 32'(TEXT_ROWS * GLYPH_ROWS / 2);
    assign left_calc = (32'(head.col) << 3)
                     + 32'(cfg.screen_width >> 1)
                     - 32'(TEXT_COLS * CELL_PIXELS / 2);

    assign rd_idx    = gbase_reg + GLYPH_IDX_W'(rd_row);
    assign rd_hit    = !rd_idx[GLYPH_IDX_W-1] && (rd_idx < GLYPH_IDX_W'(STORE_DEPTH));
    assign ram_raddr = rd_idx[STORE_AW-1:0];
    assign bits      = hit_reg ? ram_rdata : 8'h00;

    assign ram_waddr = head.font_index;
    assign ram_wdata = head.font_byte;

    always_comb
    begin
        state_next     = state_reg;
        grow_next      = grow_reg;
        out_valid_next = out_valid_reg;
        gbase_next     = gbase_reg;
        top_next       = top_reg;
        off_next       = off_reg;
        prod_next      = prod_reg;
        addr_next      = addr_reg;
        hit_next       = hit_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        rd_row         = grow_reg;

        // Drop the beat once taken
        if (out_valid_reg && pix_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (head.kind == KIND_LOAD)
                    begin
                        ram_we = (head.font_index < STORE_AW'(STORE_DEPTH));
                    end
                    else
                    begin
                        gbase_next = head.glyph_base;
                        top_next   = top_calc;
                        off_next   = cfg.fb_base + (left_calc << PIXEL_SHIFT);
                        state_next = BK_SETUP;
                    end
                end
            end
            BK_SETUP:
            begin
                prod_next  = 32'(top_reg * {16'h0000, cfg.line_pitch});
                state_next = BK_BASE;
            end
            BK_BASE:
            begin
                addr_next  = prod_reg + off_reg;
                grow_next  = '0;
                rd_row     = '0;
                ram_re     = 1'b1;
                hit_next   = rd_hit;
                state_next = BK_ROW;
            end
            BK_ROW:
            begin
                if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.row_address = addr_reg;
                    out_next.px0         = bits[7] ? cfg.fg_color : cfg.bg_color;
                    out_next.px1         = bits[6] ? cfg.fg_color : cfg.bg_color;
                    out_next.px2         = bits[5] ? cfg.fg_color : cfg.bg_color;
                    out_next.px3         = bits[4] ? cfg.fg_color : cfg.bg_color;
                    out_next.px4         = bits[3] ? cfg.fg_color : cfg.bg_color;
                    out_next.px5         = bits[2] ? cfg.fg_color : cfg.bg_color;
                    out_next.px6         = bits[1] ? cfg.fg_color : cfg.bg_color;
                    out_next.px7         = bits[0] ? cfg.fg_color : cfg.bg_color;
                    out_next.last_row    = (grow_reg == GR_W'(GLYPH_ROWS - 1));
                    addr_next            = addr_reg + 32'(cfg.line_pitch);
                    if (grow_reg == GR_W'(GLYPH_ROWS - 1))
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        // Fetch the next glyph row while this beat goes out
                        grow_next = grow_reg + GR_W'(1);
                        rd_row    = grow_reg + GR_W'(1);
                        ram_re    = 1'b1;
                        hit_next  = rd_hit;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            grow_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grow_reg      <= grow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gbase_reg <= gbase_next;
        top_reg   <= top_next;
        off_reg   <= off_next;
        prod_reg  <= prod_next;
        addr_reg  <= addr_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

endmodule

### src/glyph_text_console_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_console_renderer
// Text console renderer: draws bitmap font glyphs as rows of eight 32-bit
// pixels into a framebuffer, with a centred text grid and a wrapping cursor.
// ----------------------------------------------------------------------------
// A font load is written to the font RAM as the back end takes it from the
// queue; the front end absorbs a newline in the cycle it is accepted.
// A drawn character passes the back end states in order: BK_IDLE takes
// it from the queue, BK_SETUP does the row-times-pitch multiply, BK_BASE the
// base address add, then BK_ROW sends one glyph row per cycle unless the
// pixel channel stalls, paced by the single read port of the font RAM. A
// four-entry queue lets the command side run ahead of drawing. The font RAM
// holds 1520 bytes and is not cleared at reset; load every glyph before
// drawing it. Configuration registers may be written only while idle.
module glyph_text_console_renderer
    import gtcr_pkg::*;
#(
    parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output pix_t                  pix,
    input  logic                  cfg_write,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [REG_DATA_W-1:0] cfg_data
);

    cfg_t                cfg_reg, cfg_next;
    q_status_t           q_status;
    q_entry_t            push_entry;
    q_entry_t            head;
    logic                push;
    logic                pop;
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic                ram_re;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]          ram_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FG_COLOR:      cfg_next.fg_color      = cfg_data;
                REG_BG_COLOR:      cfg_next.bg_color      = cfg_data;
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[12:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[12:0];
                REG_LINE_PITCH:    cfg_next.line_pitch    = cfg_data[15:0];
                REG_FB_BASE:       cfg_next.fb_base       = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color      <= '0;
            cfg_reg.bg_color      <= '0;
            cfg_reg.screen_width  <= SCREEN_WIDTH_RESET;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RESET;
            cfg_reg.line_pitch    <= LINE_PITCH_RESET;
            cfg_reg.fb_base       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gtcr_front #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_status  (q_status),
        .push      (push),
        .entry     (push_entry)
    );

    gtcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    gtcr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gtcr_back #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // Hold a stalled pixel beat unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_ready) |=> (pix_valid && $stable(pix)))
        else $error("stalled pixel beat dropped or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !q_status.empty)
        else $error("queue reports full and empty at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |-> !q_status.full)
        else $error("command beat taken while the queue is full");

endmodule

### dv/glyph_text_console_renderer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_console_renderer_test
// Self-checking bench for the glyph text console renderer. Font bytes and
// characters go in as command beats. A shadow of the font store, the cursor
// and the registers works out the pixel rows each character must produce,
// and every pixel beat is checked field by field against the oldest one due.
// Directed cases cover reset values, field extremes, glyph fallback to space,
// ignored font indexes and cursor wrap. Random traffic then runs under
// several register settings and idle/stall mixes, with one long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module glyph_text_console_renderer_test;
    import gtcr_pkg::*;

    localparam int ROWS_PER_GLYPH = GLYPH_ROWS_DEFAULT;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int PHASE_ITEMS    = 40;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd;
    logic                  pix_valid;
    logic                  pix_ready;
    pix_t                  pix;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [REG_DATA_W-1:0] cfg_data;

    // Shadow state of the renderer
    logic [7:0]       font_shadow [STORE_DEPTH];
    bit               font_loaded [STORE_DEPTH];
    logic [COL_W-1:0] cur_col = '0;
    logic [ROW_W-1:0] cur_row = '0;
    cfg_t             cfg_shadow;
    pix_t             rows_due [$];
    pix_t             want_row;

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_off_cycles = 0;
    int errors          = 0;
    int live_items      = 0;
    int loads_sent      = 0;
    int chars_drawn     = 0;
    int newlines_sent   = 0;
    int rows_checked    = 0;
    int settings_used   = 0;

    glyph_text_console_renderer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------
    function automatic int glyph_of(input logic [7:0] code);
        if (code < FIRST_GLYPH || code > LAST_GLYPH)
            return int'(CHAR_SPACE);
        return int'(code);
    endfunction

    function automatic bit glyph_ready(input int code);
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
        begin
            if (!font_loaded[(code - FIRST_GLYPH) * ROWS_PER_GLYPH + r])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] shade(input logic bit_set);
        return bit_set ? cfg_shadow.fg_color : cfg_shadow.bg_color;
    endfunction

    function automatic void next_text_row();
        cur_row = cur_row + 1'b1;
        if (cur_row >= TEXT_ROWS)
            cur_row = '0;
    endfunction

    function automatic void compute_glyph_rows(input cmd_t c);
        logic [31:0] top;
        logic [31:0] left;
        logic [7:0]  bits;
        int          g;
        pix_t        p;
        if (c.action == ACTION_LOAD)
        begin
            if (c.font_index < STORE_DEPTH)
            begin
                font_shadow[c.font_index] = c.font_byte;
                font_loaded[c.font_index] = 1'b1;
            end
            return;
        end
        if (c.char_code == CHAR_NEWLINE)
        begin
            cur_col = '0;
            next_text_row();
            return;
        end
        // wrap first when the cursor sits past the last column
        if (cur_col >= TEXT_COLS)
        begin
            cur_col = '0;
            next_text_row();
        end
        g = glyph_of(c.char_code);
        top = 32'(cur_row) * ROWS_PER_GLYPH
            + (32'(cfg_shadow.screen_height) / 2 - 32'(TEXT_ROWS * ROWS_PER_GLYPH / 2));
        left = 32'(cur_col) * CELL_PIXELS
            + (32'(cfg_shadow.screen_width) / 2 - 32'(TEXT_COLS * CELL_PIXELS / 2));
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
        begin
            bits = font_shadow[(g - FIRST_GLYPH) * ROWS_PER_GLYPH + r];
            p.row_address = cfg_shadow.fb_base
                + (top + 32'(r)) * 32'(cfg_shadow.line_pitch) + (left << PIXEL_SHIFT);
            p.px0 = shade(bits[7]);
            p.px1 = shade(bits[6]);
            p.px2 = shade(bits[5]);
            p.px3 = shade(bits[4]);
            p.px4 = shade(bits[3]);
            p.px5 = shade(bits[2]);
            p.px6 = shade(bits[1]);
            p.px7 = shade(bits[0]);
            p.last_row = (r == ROWS_PER_GLYPH - 1);
            rows_due.push_back(p);
        end
        cur_col = cur_col + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Pixel side: ready generation and checking
    // ------------------------------------------------------------------
    initial
    begin
        pix_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                pix_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                pix_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pix_valid && pix_ready)
        begin
            if (rows_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel beat, expected none, actual %h", $time, pix);
            end
            else
            begin
                want_row = rows_due.pop_front();
                rows_checked++;
                check_field("row_address", want_row.row_address, pix.row_address);
                check_field("px0", want_row.px0, pix.px0);
                check_field("px1", want_row.px1, pix.px1);
                check_field("px2", want_row.px2, pix.px2);
                check_field("px3", want_row.px3, pix.px3);
                check_field("px4", want_row.px4, pix.px4);
                check_field("px5", want_row.px5, pix.px5);
                check_field("px6", want_row.px6, pix.px6);
                check_field("px7", want_row.px7, pix.px7);
                check_field("last_row", 32'(want_row.last_row), 32'(pix.last_row));
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("Timeout with %0d pixel rows still due", rows_due.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    task automatic send_cmd(input cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        compute_glyph_rows(c);
        if (c.action == ACTION_LOAD)
        begin
            loads_sent++;
            if (c.font_index < STORE_DEPTH)
                live_items++;
        end
        else
        begin
            live_items++;
            if (c.char_code == CHAR_NEWLINE)
                newlines_sent++;
            else
                chars_drawn++;
        end
    endtask

    task automatic load_font_byte(input int idx, input logic [7:0] value);
        cmd_t c;
        c.action     = ACTION_LOAD;
        c.font_index = 11'(idx);
        c.font_byte  = value;
        c.char_code  = 8'($urandom_range(255));
        send_cmd(c);
    endtask

    task automatic load_glyph(input int code);
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
            load_font_byte((code - FIRST_GLYPH) * ROWS_PER_GLYPH + r, 8'($urandom_range(255)));
    endtask

    // Load the glyph first if any of its rows was never written
    task automatic put_char(input logic [7:0] code);
        cmd_t c;
        if (code != CHAR_NEWLINE && !glyph_ready(glyph_of(code)))
            load_glyph(glyph_of(code));
        c.action     = ACTION_PUT;
        c.font_index = 11'($urandom_range(2047));
        c.font_byte  = 8'($urandom_range(255));
        c.char_code  = code;
        send_cmd(c);
    endtask

    // Fall back to the space glyph, which is loaded first of all
    function automatic logic [7:0] pick_loaded_code();
        int code;
        code = FIRST_GLYPH;
        for (int tries = 0; tries < 6; tries++)
        begin
            code = $urandom_range(LAST_GLYPH, FIRST_GLYPH);
            if (glyph_ready(code))
                return 8'(code);
        end
        return CHAR_SPACE;
    endfunction

    task automatic wait_drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(negedge clk);
        // loads and newlines leave nothing to wait for, so let the pipe settle
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FG_COLOR:      cfg_shadow.fg_color      = value;
            REG_BG_COLOR:      cfg_shadow.bg_color      = value;
            REG_SCREEN_WIDTH:  cfg_shadow.screen_width  = value[12:0];
            REG_SCREEN_HEIGHT: cfg_shadow.screen_height = value[12:0];
            REG_LINE_PITCH:    cfg_shadow.line_pitch    = value[15:0];
            REG_FB_BASE:       cfg_shadow.fb_base       = value;
            default: ;
        endcase
    endtask

    // Upper bits of narrow registers carry junk that must be dropped
    task automatic apply_setting(input logic [31:0] fg, input logic [31:0] bg,
                                 input logic [12:0] w, input logic [12:0] h,
                                 input logic [15:0] pitch, input logic [31:0] base);
        wait_drain();
        write_reg(REG_FG_COLOR, fg);
        write_reg(REG_BG_COLOR, bg);
        write_reg(REG_SCREEN_WIDTH, {19'($urandom()), w});
        write_reg(REG_SCREEN_HEIGHT, {19'($urandom()), h});
        write_reg(REG_LINE_PITCH, {16'($urandom()), pitch});
        write_reg(REG_FB_BASE, base);
        write_reg(REG_UNUSED_6, $urandom());
        write_reg(REG_UNUSED_7, $urandom());
        settings_used++;
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            put_char(CHAR_NEWLINE);
        else if (pick < 14)
            load_font_byte($urandom_range(2047), 8'($urandom_range(255)));
        else if (pick < 20)
            load_glyph($urandom_range(LAST_GLYPH, FIRST_GLYPH));
        else if (pick < 35)
            put_char(8'($urandom_range(255)));
        else
            put_char(pick_loaded_code());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        logic [7:0] pattern [8];
        pattern = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0};
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
            load_font_byte(r, (r < 8) ? pattern[r] : 8'($urandom_range(255)));
        load_glyph(LAST_GLYPH);
        put_char(CHAR_SPACE);
        put_char(8'(LAST_GLYPH));
    endtask

    task automatic test_field_extremes();
        apply_setting(32'hFFFF_FFFF, 32'h0, SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET,
                      LINE_PITCH_RESET, 32'h0);
        put_char(8'(FIRST_GLYPH));
        put_char(8'(LAST_GLYPH));
        put_char(8'(FIRST_GLYPH - 1));
        put_char(8'(LAST_GLYPH + 1));
        put_char(8'h80);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(CHAR_NEWLINE);
        // indexes past the store are dropped
        load_font_byte(2047, 8'hFF);
        load_font_byte(STORE_DEPTH, 8'hFF);
        load_font_byte(0, 8'hFF);
        put_char(CHAR_SPACE);
    endtask

    task automatic test_row_wrap();
        repeat (TEXT_ROWS - 1) put_char(CHAR_NEWLINE);
        put_char(8'(LAST_GLYPH));
        put_char(CHAR_NEWLINE);
        put_char(CHAR_SPACE);
    endtask

    task automatic test_line_overflow();
        repeat (TEXT_COLS + 2) put_char(pick_loaded_code());
    endtask

    task automatic test_register_extremes();
        apply_setting(32'hFFFF_FFFF, 32'h0, 13'd0, 13'd0, 16'd0, 32'h0);
        repeat (4) send_random_item();
        apply_setting(32'h0, 32'hFFFF_FFFF, 13'h1FFF, 13'h1FFF, 16'hFFFF, 32'hFFFF_FFFF);
        repeat (4) send_random_item();
        apply_setting($urandom(), $urandom(), 13'd1, 13'd1, 16'hFFFF, $urandom());
        repeat (4) send_random_item();
        apply_setting($urandom(), $urandom(), 13'($urandom()), 13'($urandom()),
                      16'($urandom()), $urandom());
        repeat (4) send_random_item();
    endtask

    task automatic run_traffic_phase(input int idle, input int stall);
        int start;
        apply_setting($urandom(), $urandom(), 13'($urandom_range(8191, 640)),
                      13'($urandom_range(8191, 400)), 16'($urandom()), $urandom());
        send_idle_pct = idle;
        stall_pct     = stall;
        start         = live_items;
        while (live_items - start < PHASE_ITEMS)
        begin
            send_random_item();
            if ($urandom_range(99) < 2)
                wait_drain();
        end
    endtask

    task automatic test_traffic_mix();
        run_traffic_phase(0, 0);
        run_traffic_phase(76, 0);
        run_traffic_phase(0, 76);
        run_traffic_phase(34, 34);
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // Hold the pixel side off while commands keep coming, so the queue fills
    task automatic test_backpressure();
        wait_drain();
        @(posedge clk);
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (12) put_char(pick_loaded_code());
        wait_drain();
    endtask

    initial
    begin
        cmd_valid  = 1'b0;
        cmd        = '0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        cfg_shadow.fg_color      = '0;
        cfg_shadow.bg_color      = '0;
        cfg_shadow.screen_width  = SCREEN_WIDTH_RESET;
        cfg_shadow.screen_height = SCREEN_HEIGHT_RESET;
        cfg_shadow.line_pitch    = LINE_PITCH_RESET;
        cfg_shadow.fb_base       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_field_extremes();
        test_row_wrap();
        test_line_overflow();
        test_register_extremes();
        test_traffic_mix();
        test_backpressure();
        wait_drain();

        $display("Covered %0d font loads, %0d characters, %0d newlines, %0d pixel rows checked",
                 loads_sent, chars_drawn, newlines_sent, rows_checked);
        $display("across %0d register settings and four idle/stall mixes; mismatches: %0d",
                 settings_used, errors);
        if (errors == 0 && rows_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
src/gtcr_pkg.sv
src/gtcr_ram.sv
src/gtcr_front.sv
src/gtcr_queue.sv
src/gtcr_back.sv
src/glyph_text_console_renderer.sv
dv/glyph_text_console_renderer_test.sv
